// ===== sv/nrb_pkg.sv =====
package nrb_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int DATA_WIDTH = 48;
  localparam int MAX_DEGREE = 63;

  localparam int DEG_W   = 6;
  localparam int STOP_W  = 25;
  localparam int EXT_W   = DATA_WIDTH + 1;
  localparam int HALF_W  = (DATA_WIDTH + 1) / 2;
  localparam int PROD_W  = 4 * HALF_W;
  localparam int APB_DW  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [STOP_W-1:0] STOP_RESET = STOP_W'(2);

  // register index, taken from paddr[2]
  localparam logic REG_STOP_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_EVEN = 2'd1,
    ST_DEG_ZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POW,
    S_MWAIT,
    S_CMP
  } state_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic [DEG_W-1:0]             root_degree;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] root_value;
    status_e                      status;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [DATA_WIDTH-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== sv/nrb_regs.sv =====
module nrb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nrb_pkg::ADDR_W-1:0] paddr,
  input  logic [nrb_pkg::APB_DW-1:0] pwdata,
  output logic [nrb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [nrb_pkg::STOP_W-1:0] stop_o
);
  import nrb_pkg::*;

  logic [STOP_W-1:0] stop_q, stop_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    stop_d = stop_q;
    if (wr_en && (paddr[2] == REG_STOP_WIDTH)) begin
      stop_d = pwdata[STOP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= STOP_RESET;
    end else begin
      stop_q <= stop_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STOP_WIDTH) begin
      prdata = {{(APB_DW-STOP_W){1'b0}}, stop_q};
    end
  end

  assign stop_o = stop_q;

endmodule

// ===== sv/nrb_mul.sv =====
module nrb_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nrb_pkg::mul_req_t req_i,
  output nrb_pkg::mul_rsp_t rsp_o
);
  import nrb_pkg::*;

  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [1:0]            ph_q, ph_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [PROD_W-1:0]     acc_q, acc_d;

  logic [2*HALF_W-1:0]   a_ext, b_ext, pp;
  logic [HALF_W-1:0]     a_part, b_part;
  logic [PROD_W-1:0]     pp_ext, pp_sh;

  assign a_ext  = (2*HALF_W)'(a_q);
  assign b_ext  = (2*HALF_W)'(b_q);
  assign a_part = ph_q[1] ? a_ext[2*HALF_W-1:HALF_W] : a_ext[HALF_W-1:0];
  assign b_part = ph_q[0] ? b_ext[2*HALF_W-1:HALF_W] : b_ext[HALF_W-1:0];
  assign pp     = a_part * b_part;
  assign pp_ext = PROD_W'(pp);

  // partial product weight is the sum of the half indexes
  always_comb begin
    unique case (ph_q)
      2'b00:        pp_sh = pp_ext;
      2'b01, 2'b10: pp_sh = pp_ext << HALF_W;
      default:      pp_sh = pp_ext << (2*HALF_W);
    endcase
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    ph_d   = ph_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      ph_d   = 2'b00;
      busy_d = 1'b1;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      ph_d  = ph_q + 2'b01;
      if (ph_q == 2'b11) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    ph_q  <= ph_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = |acc_q[PROD_W-1:FRAC_BITS+DATA_WIDTH-1];
  assign rsp_o.prod = {1'b0, acc_q[FRAC_BITS+DATA_WIDTH-2:FRAC_BITS]};

endmodule

// ===== sv/nth_root_bisection_core.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+-------------------------------
// input     | start & !busy                 | in_i  (x_value, root_degree)
// result    | out_valid_o, one-cycle strobe | out_o (root_value, status)
// config    | apb write: psel penable pwrite| paddr, pwdata, prdata
//
// one transaction at a time; busy stays high until its result is strobed
// error cases (degree zero, even root of negative) answer the cycle after start
// otherwise steps ~ log2(width/stop_width) halvings, each with up to n-1 multiplies
// every multiply runs on the shared 4-pass partial-product multiplier
// reset is asynchronous and active low; stop_width resets to 2
// the result is shown for one cycle only, the receiver cannot stall it
module nth_root_bisection_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  nrb_pkg::in_t               in_i,
  output logic                       out_valid_o,
  output nrb_pkg::out_t              out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nrb_pkg::ADDR_W-1:0] paddr,
  input  logic [nrb_pkg::APB_DW-1:0] pwdata,
  output logic [nrb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import nrb_pkg::*;

  localparam logic signed [EXT_W-1:0] ONE_Q = EXT_W'(1) << FRAC_BITS;

  state_e state_q, state_d;

  // search datapath
  logic signed [DATA_WIDTH-1:0] x_q, x_d;
  logic [DEG_W-1:0]             n_q, n_d, cnt_q, cnt_d;
  logic signed [EXT_W-1:0]      low_q, low_d, high_q, high_d, m_q, m_d;
  logic [DATA_WIDTH-1:0]        mag_q, mag_d, p_q, p_d;
  logic                         ovf_q, ovf_d;
  logic [STOP_W-1:0]            stop_q, stop_d;
  logic                         out_valid_q, out_valid_d;
  out_t                         out_q, out_d;

  logic [STOP_W-1:0]            stop_cfg, stop_eff;
  logic                         accept;
  logic [DEG_W-1:0]             n_clamp;
  logic signed [EXT_W-1:0]      x_in_ext, x_ext, mid, m_neg, p_ext, pw;
  logic [EXT_W-1:0]             width;
  logic                         more, err_zero, err_neg, mneg, pneg, below;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  nrb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stop_o  (stop_cfg)
  );

  nrb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // input decode: degree clamp and the two error cases
  assign n_clamp  = (int'(in_i.root_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                            : in_i.root_degree;
  assign err_zero = (in_i.root_degree == '0);
  assign err_neg  = in_i.x_value[DATA_WIDTH-1] && !n_clamp[0];
  assign x_in_ext = {in_i.x_value[DATA_WIDTH-1], in_i.x_value};

  // a zero stop width would never end the search
  assign stop_eff = (stop_cfg == '0) ? STOP_W'(1) : stop_cfg;

  // interval width and midpoint, bounds always satisfy low <= high
  assign x_ext = {x_q[DATA_WIDTH-1], x_q};
  assign width = high_q - low_q;
  assign mid   = low_q + $signed(width >> 1);
  assign more  = width > {{(EXT_W-STOP_W){1'b0}}, stop_q};
  assign m_neg = -mid;

  // sign of the power is applied only at the compare
  assign mneg  = m_q[EXT_W-1];
  assign pneg  = mneg && n_q[0];
  assign p_ext = {1'b0, p_q};
  assign pw    = pneg ? -p_ext : p_ext;
  // an overflowed power lies beyond every radicand on its own side
  assign below = ovf_q ? pneg : (pw < x_ext);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !err_zero && !err_neg) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = more ? S_POW : S_IDLE;
      S_POW:   state_d = (cnt_q < n_q) ? S_MWAIT : S_CMP;
      S_MWAIT: begin
        if (mul_rsp.done) begin
          state_d = mul_rsp.ovf ? S_CMP : S_POW;
        end
      end
      S_CMP:   state_d = S_CHECK;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    x_d         = x_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    low_d       = low_q;
    high_d      = high_q;
    m_d         = m_q;
    mag_d       = mag_q;
    p_d         = p_q;
    ovf_d       = ovf_q;
    stop_d      = stop_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    mul_req     = '{start: 1'b0, a: p_q, b: mag_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          x_d    = in_i.x_value;
          n_d    = n_clamp;
          stop_d = stop_eff;
          if (x_in_ext < ONE_Q) begin
            low_d  = x_in_ext;
            high_d = ONE_Q;
          end else begin
            low_d  = '0;
            high_d = x_in_ext;
          end
          if (err_zero) begin
            out_valid_d = 1'b1;
            out_d       = '{root_value: '0, status: ST_DEG_ZERO};
          end else if (err_neg) begin
            out_valid_d = 1'b1;
            out_d       = '{root_value: '0, status: ST_NEG_EVEN};
          end
        end
      end
      S_CHECK: begin
        m_d   = mid;
        mag_d = mid[EXT_W-1] ? m_neg[DATA_WIDTH-1:0] : mid[DATA_WIDTH-1:0];
        p_d   = mid[EXT_W-1] ? m_neg[DATA_WIDTH-1:0] : mid[DATA_WIDTH-1:0];
        cnt_d = DEG_W'(1);
        ovf_d = 1'b0;
        if (!more) begin
          out_valid_d = 1'b1;
          out_d       = '{root_value: mid[DATA_WIDTH-1:0], status: ST_OK};
        end
      end
      S_POW: begin
        mul_req.start = (cnt_q < n_q);
      end
      S_MWAIT: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            ovf_d = 1'b1;
          end else begin
            p_d   = mul_rsp.prod;
            cnt_d = cnt_q + DEG_W'(1);
          end
        end
      end
      S_CMP: begin
        if (below) begin
          low_d = m_q;
        end else begin
          high_d = m_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    low_q  <= low_d;
    high_q <= high_d;
    m_q    <= m_d;
    mag_q  <= mag_d;
    p_q    <= p_d;
    ovf_q  <= ovf_d;
    stop_q <= stop_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/nrb_chk.sv =====
module nrb_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          out_valid_o,
  input nrb_pkg::out_t out_o,
  input logic          pready
);
  import nrb_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // an accepted transaction keeps the block busy or answers at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || out_valid_o))
    else $error("accepted transaction neither busy nor answered");

  // a result is only strobed once the search has ended
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result strobed while busy");

  // strobe lasts a single cycle unless a new error transaction answers
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accept) |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  // error status always comes with a zero root
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status != ST_OK)) |-> (out_o.root_value == '0))
    else $error("error result with nonzero root");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind nth_root_bisection_core nrb_chk u_nrb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .out_o       (out_o),
  .pready      (pready)
);
